// ----- src/sthp_pkg.sv -----
// Shared types and constants of the symbol table hash probe engine.
// No dependencies; imported by the interfaces, the top level and the checker.
package sthp_pkg;

	localparam int KEY_BYTES        = 8;
	localparam int NAME_CHARS       = 8;
	localparam int DEF_TABLE_SLOTS  = 1024;
	localparam int DEF_LABEL_DIGITS = 10;
	localparam int HASH_MUL         = 79;
	localparam int CHAR_BIAS        = 32;
	localparam int INDEX_W          = 10;
	localparam int DIGIT_W          = 4;
	// hash sum h*79 + c + bias stays below VSUM_RATIO * slots
	localparam int VSUM_RATIO       = 96;
	localparam int QUO_W            = $clog2(VSUM_RATIO);

	typedef enum logic [1:0] {
		OP_NAMED = 2'd0,
		OP_ANON  = 2'd1,
		OP_LREF  = 2'd2,
		OP_LDEF  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_FOUND      = 3'd0,
		ST_CREATED    = 3'd1,
		ST_FULL       = 3'd2,
		ST_BAD_DIGIT  = 3'd3,
		ST_UNDEF_BACK = 3'd4
	} status_t;

endpackage

// ----- src/sthp_if.sv -----
// Valid/ready channels of the symbol table hash probe: request and response items.
// Depends on sthp_pkg.
interface sthp_req_if;
	logic                               valid;
	logic                               ready;
	sthp_pkg::op_t                      op;
	logic [63:0]                        name_key;
	logic [sthp_pkg::DIGIT_W-1:0]       label_digit;
	logic                               label_forward;

	modport source (output valid, op, name_key, label_digit, label_forward, input ready);
	modport sink   (input valid, op, name_key, label_digit, label_forward, output ready);
endinterface

interface sthp_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [sthp_pkg::INDEX_W-1:0]       symbol_index;
	sthp_pkg::status_t                  status;

	modport source (output valid, symbol_index, status, input ready);
	modport sink   (input valid, symbol_index, status, output ready);
endinterface

// ----- src/symbol_table_hash_probe.sv -----
// Symbol table engine: hash unit, linear-probe sequencer over the slot memory, label file.
// Depends on sthp_pkg and the channel interfaces in sthp_if.sv.
//
// After reset the engine sweeps the slot memory, one slot a cycle; req.ready stays low
// until the sweep ends. One item is worked on at a time. An anonymous symbol or a numeric
// label item goes from acceptance to S_EXEC and from there to its result. A named lookup
// hashes the name character by character and then probes slots in turn: the hash is reduced
// modulo TABLE_SLOTS by one shared multiply-and-correct unit in three steps per character,
// and each probe is a registered read of the slot memory followed by the compare. A finished
// result sits in the output register, and the next item is accepted while it waits.
module symbol_table_hash_probe #(
	parameter int TABLE_SLOTS  = sthp_pkg::DEF_TABLE_SLOTS,
	parameter int LABEL_DIGITS = sthp_pkg::DEF_LABEL_DIGITS
) (
	input  logic       clk,
	input  logic       arst_n,
	sthp_req_if.sink   req,
	sthp_rsp_if.source rsp
);
	import sthp_pkg::*;

	localparam int SW     = $clog2(TABLE_SLOTS);
	localparam int CW     = $clog2(TABLE_SLOTS + 1);
	localparam int IW     = SW;
	localparam int VW     = $clog2(VSUM_RATIO * TABLE_SLOTS);
	localparam int PW     = 2 * VW;
	localparam int RECIP  = (2 ** VW) / TABLE_SLOTS;
	localparam int BIAS   = TABLE_SLOTS - (CHAR_BIAS % TABLE_SLOTS);
	localparam int LABELS = 2 * LABEL_DIGITS;
	localparam int LW     = (LABELS > 1) ? $clog2(LABELS) : 1;
	localparam int CIW    = $clog2(KEY_BYTES + 1);

	typedef enum logic [7:0] {
		S_CLEAR     = 8'b0000_0001,
		S_IDLE      = 8'b0000_0010,
		S_HASH_MUL  = 8'b0000_0100,
		S_HASH_QUO  = 8'b0000_1000,
		S_HASH_RED  = 8'b0001_0000,
		S_PROBE_RD  = 8'b0010_0000,
		S_PROBE_CHK = 8'b0100_0000,
		S_EXEC      = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic          used;
		logic [IW-1:0] sym;
		logic [63:0]   key;
	} slot_t;

	state_t              state_q;
	op_t                 op_q;
	logic [DIGIT_W-1:0]  digit_q;
	logic                fwd_q;
	logic [63:0]         key_q;
	logic [SW-1:0]       h_q;
	logic [CIW-1:0]      ci_q;
	logic [VW-1:0]       v_q;
	logic [QUO_W-1:0]    q_q;
	logic [SW-1:0]       s_q;
	logic [CW-1:0]       probes_q;
	logic [SW-1:0]       clr_q;
	logic [CW-1:0]       count_q;
	logic [LABELS-1:0]   label_valid_q;
	logic [IW-1:0]       label_sym_q [LABELS];
	logic                out_valid_q;
	logic [INDEX_W-1:0]  out_idx_q;
	status_t             out_status_q;

	slot_t               slot_mem [TABLE_SLOTS];
	slot_t               slot_rd_q;
	logic                mem_we;
	logic [SW-1:0]       mem_wa;
	slot_t               mem_wd;

	logic [63:0]         clean_key;
	logic                alive;
	logic [7:0]          ch;
	logic                hash_end;
	logic [PW-1:0]       prod;
	logic [VW-1:0]       rem;
	logic [SW-1:0]       red;
	logic                out_free;
	logic                cnt_full;
	logic                slot_hit;
	logic [SW-1:0]       s_next;
	logic                dig_bad;
	logic [LW-1:0]       e_ref;
	logic [LW-1:0]       e_fwd;
	logic [LW-1:0]       e_bwd;
	logic [LW-1:0]       e_rd;
	logic [IW-1:0]       lab_sym;

	// name ends at the first zero byte or after NAME_CHARS characters
	always_comb begin
		clean_key = '0;
		alive = 1'b1;
		for (int i = 0; i < KEY_BYTES; i++) begin
			alive = alive && (i < NAME_CHARS) && (req.name_key[8*i +: 8] != 8'd0);
			if (alive) begin
				clean_key[8*i +: 8] = req.name_key[8*i +: 8];
			end
		end
	end

	assign ch       = key_q[{ci_q[2:0], 3'b000} +: 8];
	assign hash_end = (ci_q == CIW'(KEY_BYTES)) || (ch == 8'd0);
	assign prod     = PW'(v_q) * PW'(RECIP);
	assign rem      = v_q - VW'(q_q) * VW'(TABLE_SLOTS);
	assign red      = (rem >= VW'(TABLE_SLOTS)) ? SW'(rem - VW'(TABLE_SLOTS)) : SW'(rem);

	assign out_free = !out_valid_q || rsp.ready;
	assign cnt_full = (count_q == CW'(TABLE_SLOTS));
	assign slot_hit = (slot_rd_q.key == key_q);
	assign s_next   = (s_q == SW'(TABLE_SLOTS - 1)) ? '0 : s_q + SW'(1);

	assign dig_bad  = ({1'b0, digit_q} >= 5'(LABEL_DIGITS));
	assign e_bwd    = LW'(digit_q);
	assign e_fwd    = LW'(6'(digit_q) + 6'(LABEL_DIGITS));
	assign e_ref    = fwd_q ? e_fwd : e_bwd;
	assign e_rd     = (op_q == OP_LDEF) ? e_fwd : e_ref;
	assign lab_sym  = label_sym_q[e_rd];

	assign mem_we = (state_q == S_CLEAR) ||
		((state_q == S_PROBE_CHK) && out_free && !slot_rd_q.used && !cnt_full);
	assign mem_wa = (state_q == S_CLEAR) ? clr_q : s_q;
	always_comb begin
		mem_wd      = '0;
		mem_wd.used = (state_q != S_CLEAR);
		mem_wd.sym  = IW'(count_q);
		mem_wd.key  = key_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_wa] <= mem_wd;
		end
		slot_rd_q <= slot_mem[s_q];
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.symbol_index = out_idx_q;
	assign rsp.status       = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			count_q       <= '0;
			label_valid_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(TABLE_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.op;
						digit_q <= req.label_digit;
						fwd_q   <= req.label_forward;
						key_q   <= clean_key;
						h_q     <= '0;
						ci_q    <= '0;
						state_q <= (req.op == OP_NAMED) ? S_HASH_MUL : S_EXEC;
					end
				end
				S_HASH_MUL: begin
					if (hash_end) begin
						s_q      <= h_q;
						probes_q <= '0;
						state_q  <= S_PROBE_RD;
					end else begin
						v_q     <= VW'(h_q) * VW'(HASH_MUL) + VW'(ch) + VW'(BIAS);
						state_q <= S_HASH_QUO;
					end
				end
				S_HASH_QUO: begin
					q_q     <= QUO_W'(prod >> VW);
					state_q <= S_HASH_RED;
				end
				S_HASH_RED: begin
					h_q     <= red;
					ci_q    <= ci_q + CIW'(1);
					state_q <= S_HASH_MUL;
				end
				S_PROBE_RD: begin
					state_q <= S_PROBE_CHK;
				end
				S_PROBE_CHK: begin
					if (out_free) begin
						if (!slot_rd_q.used) begin
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
							if (cnt_full) begin
								out_idx_q    <= '0;
								out_status_q <= ST_FULL;
							end else begin
								count_q      <= count_q + CW'(1);
								out_idx_q    <= INDEX_W'(count_q);
								out_status_q <= ST_CREATED;
							end
						end else if (slot_hit) begin
							out_valid_q  <= 1'b1;
							out_idx_q    <= INDEX_W'(slot_rd_q.sym);
							out_status_q <= ST_FOUND;
							state_q      <= S_IDLE;
						end else if (probes_q == CW'(TABLE_SLOTS - 1)) begin
							out_valid_q  <= 1'b1;
							out_idx_q    <= '0;
							out_status_q <= ST_FULL;
							state_q      <= S_IDLE;
						end else begin
							probes_q <= probes_q + CW'(1);
							s_q      <= s_next;
							state_q  <= S_PROBE_RD;
						end
					end
				end
				S_EXEC: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (op_q == OP_ANON) begin
							if (cnt_full) begin
								out_idx_q    <= '0;
								out_status_q <= ST_FULL;
							end else begin
								count_q      <= count_q + CW'(1);
								out_idx_q    <= INDEX_W'(count_q);
								out_status_q <= ST_CREATED;
							end
						end else if (dig_bad) begin
							out_idx_q    <= '0;
							out_status_q <= ST_BAD_DIGIT;
						end else if (op_q == OP_LREF) begin
							if (label_valid_q[e_ref]) begin
								out_idx_q    <= INDEX_W'(lab_sym);
								out_status_q <= ST_FOUND;
							end else if (cnt_full) begin
								out_idx_q    <= '0;
								out_status_q <= ST_FULL;
							end else begin
								count_q               <= count_q + CW'(1);
								label_valid_q[e_ref]  <= 1'b1;
								label_sym_q[e_ref]    <= IW'(count_q);
								out_idx_q             <= INDEX_W'(count_q);
								out_status_q          <= fwd_q ? ST_CREATED : ST_UNDEF_BACK;
							end
						end else begin
							if (label_valid_q[e_fwd]) begin
								label_valid_q[e_bwd] <= 1'b1;
								label_valid_q[e_fwd] <= 1'b0;
								label_sym_q[e_bwd]   <= lab_sym;
								out_idx_q            <= INDEX_W'(lab_sym);
								out_status_q         <= ST_FOUND;
							end else if (cnt_full) begin
								out_idx_q    <= '0;
								out_status_q <= ST_FULL;
							end else begin
								count_q              <= count_q + CW'(1);
								label_valid_q[e_bwd] <= 1'b1;
								label_valid_q[e_fwd] <= 1'b0;
								label_sym_q[e_bwd]   <= IW'(count_q);
								out_idx_q            <= INDEX_W'(count_q);
								out_status_q         <= ST_CREATED;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/sthp_checker.sv -----
// Port-level checks of the symbol table hash probe, bound to the top level.
// Depends on sthp_pkg and symbol_table_hash_probe.
module sthp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [sthp_pkg::INDEX_W-1:0] symbol_index,
	input sthp_pkg::status_t            status
);
	import sthp_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(symbol_index) && $stable(status))
		else $error("response item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted again before the item was worked");

	a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready && !req_valid |=> !$rose(rsp_valid))
		else $error("response item without a request item");

	a_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_FULL || status == ST_BAD_DIGIT) |-> symbol_index == '0)
		else $error("nonzero index with full or bad digit status");

endmodule

bind symbol_table_hash_probe sthp_checker u_sthp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.symbol_index (rsp.symbol_index),
	.status       (rsp.status)
);
